### rtl/rgbnv_pkg.sv
// Shared types and constants for the RGB to NV12/NV21 quad converter.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package rgbnv_pkg;

  // Pixels per 2x2 quad.
  localparam int unsigned PIX_COUNT = 4;

  // BT.601 studio-range coefficients (magnitudes; signs are in the lane math).
  localparam logic [7:0] Y_R_COEF  = 8'd66;
  localparam logic [7:0] Y_G_COEF  = 8'd129;
  localparam logic [7:0] Y_B_COEF  = 8'd25;
  localparam logic [7:0] CB_R_COEF = 8'd38;
  localparam logic [7:0] CB_G_COEF = 8'd74;
  localparam logic [7:0] CB_B_COEF = 8'd112;
  localparam logic [7:0] CR_R_COEF = 8'd112;
  localparam logic [7:0] CR_G_COEF = 8'd94;
  localparam logic [7:0] CR_B_COEF = 8'd18;

  // Rounding term and offsets. The chroma bias folds the +128 offset into
  // the sum before the shift, so the shift of a signed value becomes unsigned.
  localparam logic [16:0] ROUND_TERM  = 17'd128;
  localparam logic [16:0] CHROMA_BIAS = 17'd32768;
  localparam logic [7:0]  LUMA_OFFSET = 8'd16;

  // Chroma sample order codes.
  localparam logic ORDER_NV12 = 1'b0;
  localparam logic ORDER_NV21 = 1'b1;

  // One RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Per-pixel conversion result of one lane.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

endpackage

`default_nettype wire

### rtl/rgbnv_in_if.sv
// Input channel interface: one 2x2 RGB quad per transfer.
// Depends on nothing.
`default_nettype none

interface rgbnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_top_left;
  logic [7:0] green_top_left;
  logic [7:0] blue_top_left;
  logic [7:0] red_top_right;
  logic [7:0] green_top_right;
  logic [7:0] blue_top_right;
  logic [7:0] red_bottom_left;
  logic [7:0] green_bottom_left;
  logic [7:0] blue_bottom_left;
  logic [7:0] red_bottom_right;
  logic [7:0] green_bottom_right;
  logic [7:0] blue_bottom_right;

  modport source (
    output valid,
    output red_top_left, green_top_left, blue_top_left,
    output red_top_right, green_top_right, blue_top_right,
    output red_bottom_left, green_bottom_left, blue_bottom_left,
    output red_bottom_right, green_bottom_right, blue_bottom_right,
    input  ready
  );

  modport sink (
    input  valid,
    input  red_top_left, green_top_left, blue_top_left,
    input  red_top_right, green_top_right, blue_top_right,
    input  red_bottom_left, green_bottom_left, blue_bottom_left,
    input  red_bottom_right, green_bottom_right, blue_bottom_right,
    output ready
  );
endinterface

`default_nettype wire

### rtl/rgbnv_out_if.sv
// Result channel interface: four luma samples and one chroma pair per transfer.
// Depends on nothing.
`default_nettype none

interface rgbnv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_top_left;
  logic [7:0] luma_top_right;
  logic [7:0] luma_bottom_left;
  logic [7:0] luma_bottom_right;
  logic [7:0] chroma_first;
  logic [7:0] chroma_second;

  modport source (
    output valid,
    output luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    output chroma_first, chroma_second,
    input  ready
  );

  modport sink (
    input  valid,
    input  luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    input  chroma_first, chroma_second,
    output ready
  );
endinterface

`default_nettype wire

### rtl/rgb_to_nv12_nv21_quad_unit.sv
// Top level of the RGB to NV12/NV21 quad converter.
// Depends on rgbnv_pkg, rgbnv_in_if, rgbnv_out_if, rgbnv_lane and rgbnv_merge.
//
// Usage:
//   in_ch carries one 2x2 quad of 8-bit RGB pixels per transfer. out_ch
//   returns four BT.601 studio-range luma samples and one averaged chroma
//   pair per quad, in input order. cfg_we/cfg_wdata write the chroma order
//   register (0 = Cb then Cr, NV12; 1 = Cr then Cb, NV21); write it only
//   while no quad is in flight.
//   A quad passes through two register stages on its way to out_ch:
//   the first stage holds the four lane results (one constant-coefficient
//   multiply-add per component in each lane), the second holds the merged
//   chroma average and the luma in the output register.
//   Throughput is one quad per cycle while out_ch takes results. Each stage
//   has its own valid bit, so a stalled receiver holds only the output
//   register and the stage behind it keeps accepting until it too is full;
//   in_ch.ready then drops. Reset (rst_n low, synchronous) empties both
//   stages and sets the chroma order to NV12.
`default_nettype none

module rgb_to_nv12_nv21_quad_unit (
  input  logic        clk,
  input  logic        rst_n,
  rgbnv_in_if.sink    in_ch,
  rgbnv_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  rgbnv_pkg::pix_t [rgbnv_pkg::PIX_COUNT-1:0] pix;
  rgbnv_pkg::ycc_t [rgbnv_pkg::PIX_COUNT-1:0] lane_ycc;
  rgbnv_pkg::ycc_t [rgbnv_pkg::PIX_COUNT-1:0] s1_ycc_r;
  logic [rgbnv_pkg::PIX_COUNT-1:0][7:0]       s1_cb;
  logic [rgbnv_pkg::PIX_COUNT-1:0][7:0]       s1_cr;
  logic [rgbnv_pkg::PIX_COUNT-1:0][7:0]       out_luma_r;
  logic                                       s1_valid_r;
  logic                                       out_valid_r;
  logic                                       chroma_order_r;
  logic                                       s1_en;
  logic                                       s2_en;
  logic [7:0]                                 merge_first;
  logic [7:0]                                 merge_second;
  logic [7:0]                                 chroma_first_r;
  logic [7:0]                                 chroma_second_r;

  // Gather the quad into lane order.
  assign pix[0] = '{in_ch.red_top_left, in_ch.green_top_left, in_ch.blue_top_left};
  assign pix[1] = '{in_ch.red_top_right, in_ch.green_top_right, in_ch.blue_top_right};
  assign pix[2] = '{in_ch.red_bottom_left, in_ch.green_bottom_left,
                    in_ch.blue_bottom_left};
  assign pix[3] = '{in_ch.red_bottom_right, in_ch.green_bottom_right,
                    in_ch.blue_bottom_right};

  // Stage enables: each stage advances when it is empty or its successor moves.
  assign s2_en       = !out_valid_r || out_ch.ready;
  assign s1_en       = !s1_valid_r || s2_en;
  assign in_ch.ready = s1_en;

  // Four conversion lanes working side by side.
  for (genvar i = 0; i < rgbnv_pkg::PIX_COUNT; i++) begin : g_lane
    rgbnv_lane u_lane (
      .pix (pix[i]),
      .ycc (lane_ycc[i])
    );
    assign s1_cb[i] = s1_ycc_r[i].cb;
    assign s1_cr[i] = s1_ycc_r[i].cr;
  end

  // Chroma merge on the registered lane results.
  rgbnv_merge u_merge (
    .cb            (s1_cb),
    .cr            (s1_cr),
    .chroma_order  (chroma_order_r),
    .chroma_first  (merge_first),
    .chroma_second (merge_second)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_order_r <= rgbnv_pkg::ORDER_NV12;
    end else if (cfg_we) begin
      chroma_order_r <= cfg_wdata;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Stage one payload: lane results.
  always_ff @(posedge clk) begin
    if (s1_en && in_ch.valid) begin
      s1_ycc_r <= lane_ycc;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      for (int i = 0; i < rgbnv_pkg::PIX_COUNT; i++) begin
        out_luma_r[i] <= s1_ycc_r[i].luma;
      end
      chroma_first_r  <= merge_first;
      chroma_second_r <= merge_second;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.luma_top_left     = out_luma_r[0];
  assign out_ch.luma_top_right    = out_luma_r[1];
  assign out_ch.luma_bottom_left  = out_luma_r[2];
  assign out_ch.luma_bottom_right = out_luma_r[3];
  assign out_ch.chroma_first      = chroma_first_r;
  assign out_ch.chroma_second     = chroma_second_r;

endmodule

`default_nettype wire

### rtl/rgbnv_lane.sv
// One conversion lane: BT.601 luma and per-pixel Cb/Cr for one RGB pixel.
// Depends on rgbnv_pkg.
`default_nettype none

module rgbnv_lane (
  input  rgbnv_pkg::pix_t pix,
  output rgbnv_pkg::ycc_t ycc
);

  logic [16:0] r_ext;
  logic [16:0] g_ext;
  logic [16:0] b_ext;
  logic [16:0] luma_sum;
  logic [16:0] cb_sum;
  logic [16:0] cr_sum;

  assign r_ext = {9'd0, pix.red};
  assign g_ext = {9'd0, pix.green};
  assign b_ext = {9'd0, pix.blue};

  // Luma: weighted sum with rounding, then the studio-range offset.
  assign luma_sum = r_ext * {9'd0, rgbnv_pkg::Y_R_COEF}
                  + g_ext * {9'd0, rgbnv_pkg::Y_G_COEF}
                  + b_ext * {9'd0, rgbnv_pkg::Y_B_COEF}
                  + rgbnv_pkg::ROUND_TERM;

  // Chroma: the bias keeps both sums positive (they stay below 2^16).
  assign cb_sum = b_ext * {9'd0, rgbnv_pkg::CB_B_COEF}
                + rgbnv_pkg::ROUND_TERM + rgbnv_pkg::CHROMA_BIAS
                - r_ext * {9'd0, rgbnv_pkg::CB_R_COEF}
                - g_ext * {9'd0, rgbnv_pkg::CB_G_COEF};

  assign cr_sum = r_ext * {9'd0, rgbnv_pkg::CR_R_COEF}
                + rgbnv_pkg::ROUND_TERM + rgbnv_pkg::CHROMA_BIAS
                - g_ext * {9'd0, rgbnv_pkg::CR_G_COEF}
                - b_ext * {9'd0, rgbnv_pkg::CR_B_COEF};

  assign ycc.luma = luma_sum[15:8] + rgbnv_pkg::LUMA_OFFSET;
  assign ycc.cb   = cb_sum[15:8];
  assign ycc.cr   = cr_sum[15:8];

endmodule

`default_nettype wire

### rtl/rgbnv_merge.sv
// Merging stage: averages the four lanes' chroma and orders the pair.
// Depends on rgbnv_pkg.
`default_nettype none

module rgbnv_merge (
  input  logic [rgbnv_pkg::PIX_COUNT-1:0][7:0] cb,
  input  logic [rgbnv_pkg::PIX_COUNT-1:0][7:0] cr,
  input  logic                                 chroma_order,
  output logic [7:0]                           chroma_first,
  output logic [7:0]                           chroma_second
);

  logic [9:0] cb_total;
  logic [9:0] cr_total;
  logic [7:0] cb_avg;
  logic [7:0] cr_avg;

  // Sum of four 8-bit values fits in 10 bits; divide by four by dropping bits.
  assign cb_total = {2'd0, cb[0]} + {2'd0, cb[1]} + {2'd0, cb[2]} + {2'd0, cb[3]};
  assign cr_total = {2'd0, cr[0]} + {2'd0, cr[1]} + {2'd0, cr[2]} + {2'd0, cr[3]};
  assign cb_avg   = cb_total[9:2];
  assign cr_avg   = cr_total[9:2];

  // NV12 sends Cb first, NV21 sends Cr first.
  always_comb begin
    case (chroma_order)
      rgbnv_pkg::ORDER_NV21: begin
        chroma_first  = cr_avg;
        chroma_second = cb_avg;
      end
      default: begin
        chroma_first  = cb_avg;
        chroma_second = cr_avg;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/rgbnv_checker.sv
// Port-level checks for the RGB to NV12/NV21 quad converter, and their bind.
// Depends on rgb_to_nv12_nv21_quad_unit and its channel interfaces.
`default_nettype none

module rgbnv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] luma_top_left,
  input logic [7:0] luma_top_right,
  input logic [7:0] luma_bottom_left,
  input logic [7:0] luma_bottom_right,
  input logic [7:0] chroma_first,
  input logic [7:0] chroma_second
);

  // A result waiting on a stalled receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while receiver stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // With the receiver ready, an accepted quad passes through stage one to the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted quad did not reach the output");

  // All samples lie in the studio range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      luma_top_left >= 8'd16 && luma_top_left <= 8'd235 &&
      luma_top_right >= 8'd16 && luma_top_right <= 8'd235 &&
      luma_bottom_left >= 8'd16 && luma_bottom_left <= 8'd235 &&
      luma_bottom_right >= 8'd16 && luma_bottom_right <= 8'd235 &&
      chroma_first >= 8'd16 && chroma_first <= 8'd240 &&
      chroma_second >= 8'd16 && chroma_second <= 8'd240)
    else $error("sample outside studio range");

endmodule

bind rgb_to_nv12_nv21_quad_unit rgbnv_checker u_rgbnv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .luma_top_left     (out_ch.luma_top_left),
  .luma_top_right    (out_ch.luma_top_right),
  .luma_bottom_left  (out_ch.luma_bottom_left),
  .luma_bottom_right (out_ch.luma_bottom_right),
  .chroma_first      (out_ch.chroma_first),
  .chroma_second     (out_ch.chroma_second)
);

`default_nettype wire

### tb/rgb_to_nv12_nv21_quad_unit_test.sv
// Self-checking testbench for rgb_to_nv12_nv21_quad_unit: streams RGB quads, predicts
// BT.601 luma and averaged chroma per quad, and checks every output transfer in order.
// Depends on rgbnv_pkg, rgbnv_in_if, rgbnv_out_if and the converter RTL.

module rgb_to_nv12_nv21_quad_unit_test;

  typedef rgbnv_pkg::pix_t quad_pix_t [rgbnv_pkg::PIX_COUNT];

  // One converted quad as it appears on the result channel.
  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
  } nv_sample_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  rgbnv_in_if  quad_in ();
  rgbnv_out_if quad_out ();

  rgb_to_nv12_nv21_quad_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (quad_in),
    .out_ch    (quad_out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nv_sample_t expected_quads[$];
  logic       chroma_order_shadow;
  bit         steady_flow;
  int         mismatch_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = ~clk;
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3000000;
    $display("rgb_to_nv12_nv21_quad_unit: mismatch");
    $finish;
  end

  // Random idle decision shared by both channel sides.
  function automatic bit take_break();
    return !steady_flow && ($urandom_range(99) < 13);
  endfunction

  function automatic rgbnv_pkg::pix_t px(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    rgbnv_pkg::pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  function automatic quad_pix_t make_quad(input rgbnv_pkg::pix_t tl,
                                          input rgbnv_pkg::pix_t tr,
                                          input rgbnv_pkg::pix_t bl,
                                          input rgbnv_pkg::pix_t br);
    quad_pix_t q;
    q[0] = tl;
    q[1] = tr;
    q[2] = bl;
    q[3] = br;
    return q;
  endfunction

  // Mix of plain random pixels, saturated corners of the cube and grays.
  function automatic rgbnv_pkg::pix_t random_pixel();
    rgbnv_pkg::pix_t p;
    int              shape;
    shape   = int'($urandom_range(9));
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    if (shape == 0) begin
      p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end else if (shape == 1) begin
      p.green = p.red;
      p.blue  = p.red;
    end
    return p;
  endfunction

  // Quads are mostly independent pixels; some are flat like a smooth image region.
  function automatic quad_pix_t random_quad();
    quad_pix_t q;
    for (int p = 0; p < rgbnv_pkg::PIX_COUNT; p++) begin
      q[p] = random_pixel();
    end
    if ($urandom_range(4) == 0) begin
      for (int p = 1; p < rgbnv_pkg::PIX_COUNT; p++) begin
        q[p] = q[0];
      end
    end
    return q;
  endfunction

  // BT.601 studio-range conversion of one quad with 4:2:0 chroma averaging.
  function automatic nv_sample_t convert_quad(input quad_pix_t q, input logic order);
    nv_sample_t  s;
    logic [7:0]  luma [rgbnv_pkg::PIX_COUNT];
    int unsigned r, g, b, lum;
    int unsigned cb_total, cr_total, cb_mean, cr_mean;
    cb_total = 0;
    cr_total = 0;
    for (int p = 0; p < rgbnv_pkg::PIX_COUNT; p++) begin
      r = {24'd0, q[p].red};
      g = {24'd0, q[p].green};
      b = {24'd0, q[p].blue};
      lum = ((66 * r + 129 * g + 25 * b + 128) >> 8) + 16;
      luma[p] = lum[7:0];
      // The 32768 bias keeps the sum positive, so the floor shift is a plain shift.
      cb_total += (112 * b + 128 + 32768 - 38 * r - 74 * g) >> 8;
      cr_total += (112 * r + 128 + 32768 - 94 * g - 18 * b) >> 8;
    end
    cb_mean = cb_total >> 2;
    cr_mean = cr_total >> 2;
    s.luma_top_left     = luma[0];
    s.luma_top_right    = luma[1];
    s.luma_bottom_left  = luma[2];
    s.luma_bottom_right = luma[3];
    if (order == rgbnv_pkg::ORDER_NV12) begin
      s.chroma_first  = cb_mean[7:0];
      s.chroma_second = cr_mean[7:0];
    end else begin
      s.chroma_first  = cr_mean[7:0];
      s.chroma_second = cb_mean[7:0];
    end
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic drive_pixels(input quad_pix_t q);
    quad_in.red_top_left       = q[0].red;
    quad_in.green_top_left     = q[0].green;
    quad_in.blue_top_left      = q[0].blue;
    quad_in.red_top_right      = q[1].red;
    quad_in.green_top_right    = q[1].green;
    quad_in.blue_top_right     = q[1].blue;
    quad_in.red_bottom_left    = q[2].red;
    quad_in.green_bottom_left  = q[2].green;
    quad_in.blue_bottom_left   = q[2].blue;
    quad_in.red_bottom_right   = q[3].red;
    quad_in.green_bottom_right = q[3].green;
    quad_in.blue_bottom_right  = q[3].blue;
  endtask

  // Offer one quad and hold it until the transfer; the prediction is queued on acceptance.
  task automatic send_quad(input quad_pix_t q);
    @(negedge clk);
    while (take_break()) begin
      quad_in.valid = 1'b0;
      drive_pixels(random_quad());
      @(negedge clk);
    end
    drive_pixels(q);
    quad_in.valid = 1'b1;
    @(posedge clk);
    while (quad_in.ready !== 1'b1) begin
      @(posedge clk);
    end
    expected_quads.push_back(convert_quad(q, chroma_order_shadow));
  endtask

  task automatic send_solid(input rgbnv_pkg::pix_t p);
    send_quad(make_quad(p, p, p, p));
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic wait_idle();
    @(negedge clk);
    quad_in.valid = 1'b0;
    while (expected_quads.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_chroma_order(input logic code);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = code;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = 1'($urandom_range(1));
    chroma_order_shadow = code;
  endtask

  // Extremes, primaries, secondaries and mixed quads under the reset order, which must be NV12.
  task automatic test_reset_order();
    send_solid(px(8'h00, 8'h00, 8'h00));
    send_solid(px(8'hFF, 8'hFF, 8'hFF));
    send_solid(px(8'hFF, 8'h00, 8'h00));
    send_solid(px(8'h00, 8'hFF, 8'h00));
    send_solid(px(8'h00, 8'h00, 8'hFF));
    send_solid(px(8'hFF, 8'hFF, 8'h00));
    send_solid(px(8'h00, 8'hFF, 8'hFF));
    send_solid(px(8'hFF, 8'h00, 8'hFF));
    send_solid(px(8'h55, 8'hAA, 8'h55));
    send_solid(px(8'hAA, 8'h55, 8'hAA));
    // Each lane gets a different color so a swapped luma position shows up.
    send_quad(make_quad(px(8'hFF, 8'h00, 8'h00), px(8'h00, 8'hFF, 8'h00),
                        px(8'h00, 8'h00, 8'hFF), px(8'hFF, 8'hFF, 8'hFF)));
    // Chroma sums that are not multiples of four exercise the truncating average.
    send_quad(make_quad(px(8'h00, 8'h00, 8'hFF), px(8'h00, 8'h00, 8'h00),
                        px(8'h00, 8'h00, 8'h00), px(8'h00, 8'h00, 8'h00)));
    send_quad(make_quad(px(8'hFF, 8'h00, 8'h00), px(8'h00, 8'hFF, 8'hFF),
                        px(8'h01, 8'h02, 8'h03), px(8'h80, 8'h7F, 8'h80)));
  endtask

  // Same kind of content with Cr first, then back to NV12; asymmetric chroma exposes a wrong order.
  task automatic test_nv21_order();
    write_chroma_order(rgbnv_pkg::ORDER_NV21);
    send_solid(px(8'hFF, 8'h00, 8'h00));
    send_solid(px(8'h00, 8'h00, 8'hFF));
    send_solid(px(8'hFF, 8'hFF, 8'h00));
    send_solid(px(8'h00, 8'hFF, 8'hFF));
    send_quad(make_quad(px(8'hFF, 8'h00, 8'h00), px(8'h00, 8'hFF, 8'h00),
                        px(8'h00, 8'h00, 8'hFF), px(8'hFF, 8'hFF, 8'hFF)));
    send_quad(make_quad(px(8'h00, 8'h00, 8'hFF), px(8'hFF, 8'hFF, 8'hFF),
                        px(8'h00, 8'h00, 8'h00), px(8'h7F, 8'h80, 8'h01)));
    write_chroma_order(rgbnv_pkg::ORDER_NV12);
    send_solid(px(8'h10, 8'h20, 8'hF0));
  endtask

  task automatic test_random_quads(input logic order, input int count);
    write_chroma_order(order);
    repeat (count) begin
      send_quad(random_quad());
    end
  endtask

  // Back-to-back transfers on both sides, no idling anywhere.
  task automatic test_no_idle_stream();
    wait_idle();
    steady_flow = 1'b1;
    test_random_quads(rgbnv_pkg::ORDER_NV21, 250);
    wait_idle();
    steady_flow = 1'b0;
  endtask

  // Result side: random backpressure, changed at the falling edge.
  initial begin
    quad_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      quad_out.ready = !take_break();
    end
  end

  // Compare each output transfer with the oldest prediction.
  initial begin
    nv_sample_t got;
    nv_sample_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && quad_out.valid === 1'b1 && quad_out.ready === 1'b1) begin
        got.luma_top_left     = quad_out.luma_top_left;
        got.luma_top_right    = quad_out.luma_top_right;
        got.luma_bottom_left  = quad_out.luma_bottom_left;
        got.luma_bottom_right = quad_out.luma_bottom_right;
        got.chroma_first      = quad_out.chroma_first;
        got.chroma_second     = quad_out.chroma_second;
        if (expected_quads.size() == 0) begin
          report_mismatch("output transfer with no quad pending");
        end else begin
          want = expected_quads.pop_front();
          compare_field("luma_top_left", got.luma_top_left, want.luma_top_left);
          compare_field("luma_top_right", got.luma_top_right, want.luma_top_right);
          compare_field("luma_bottom_left", got.luma_bottom_left, want.luma_bottom_left);
          compare_field("luma_bottom_right", got.luma_bottom_right, want.luma_bottom_right);
          compare_field("chroma_first", got.chroma_first, want.chroma_first);
          compare_field("chroma_second", got.chroma_second, want.chroma_second);
        end
      end
    end
  end

  // Main sequence: reset, directed tests, random phases, then the verdict.
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    chroma_order_shadow = rgbnv_pkg::ORDER_NV12;
    steady_flow         = 1'b0;
    mismatch_count      = 0;
    quad_in.valid       = 1'b0;
    drive_pixels(make_quad(px(8'h00, 8'h00, 8'h00), px(8'h00, 8'h00, 8'h00),
                           px(8'h00, 8'h00, 8'h00), px(8'h00, 8'h00, 8'h00)));
    repeat (9) begin
      @(posedge clk);
    end
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_order();
    test_nv21_order();
    test_random_quads(rgbnv_pkg::ORDER_NV21, 300);
    test_random_quads(rgbnv_pkg::ORDER_NV12, 300);
    test_no_idle_stream();
    test_random_quads(rgbnv_pkg::ORDER_NV21, 140);
    test_random_quads(rgbnv_pkg::ORDER_NV12, 140);

    // Drain, then leave room for any stray output transfer.
    wait_idle();
    repeat (8) begin
      @(posedge clk);
    end
    if (mismatch_count == 0) begin
      $display("rgb_to_nv12_nv21_quad_unit: match");
    end else begin
      $display("rgb_to_nv12_nv21_quad_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rgbnv_pkg.sv
rtl/rgbnv_in_if.sv
rtl/rgbnv_out_if.sv
rtl/rgbnv_lane.sv
rtl/rgbnv_merge.sv
rtl/rgb_to_nv12_nv21_quad_unit.sv
rtl/rgbnv_checker.sv
tb/rgb_to_nv12_nv21_quad_unit_test.sv
